### rtl/bris_pkg.sv
// shared constants, codes and handshake structs for the rotate-invert scrambler
`timescale 1ns / 1ps
`default_nettype none
package bris_pkg;

  // packet store geometry
  localparam int MAX_BYTES = 64;
  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BITS_W    = CNT_W + 3;

  // rotation amount and the bit-serial modulo unit
  localparam int AMT_W  = 16;
  localparam int STEP_W = $clog2(AMT_W);

  // byte constants
  localparam logic [7:0] INV_MASK = 8'hFF;

  // direction codes
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;

  // register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_AMOUNT    = 2'd1;
  localparam logic [1:0] REG_DECODE    = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_PREP,
    ST_PRIME,
    ST_RD,
    ST_CALC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic start_div;
    logic prep;
    logic fetch;
    logic keep_prev;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_busy;
    logic last_b;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/buffer_rotate_invert_scrambler.sv
// top level of the packet rotate-invert scrambler
// Bytes of a packet are taken one per cycle while the block is loading into
// a 64-byte store; bytes past 64 are dropped and every output word of that
// packet carries the overflow flag in m_tuser. After the word marked tlast,
// a bit-serial modulo unit reduces the rotation amount by the packet length
// in bits, a setup state fixes the rotation and a prime state starts the
// store read; then each output word takes one store read and one shift and
// invert step. The output register lets the next packet start loading while
// the final word still waits. Configuration is accepted every cycle and
// should only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module buffer_rotate_invert_scrambler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [7:0] out_byte
  output logic             m_tlast,
  output logic             m_tuser,   // [0] overflow
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  bris_pkg::ctrl_cmd_t cmd;
  bris_pkg::dp_stat_t  stat;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  bris_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bris_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_ovf   (m_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule
`default_nettype wire

### rtl/bris_mod.sv
// bit-serial restoring modulo: amount mod packet bit length, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bris_mod (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bris_pkg::AMT_W-1:0]  dividend,
  input  wire logic [bris_pkg::BITS_W-1:0] divisor,
  output logic      [bris_pkg::BITS_W-1:0] rem,
  output logic                            done
);

  logic                          busy;
  logic [bris_pkg::STEP_W-1:0]   step;
  logic [bris_pkg::AMT_W-1:0]    shreg;
  logic [bris_pkg::BITS_W:0]     trial;
  logic [bris_pkg::BITS_W-1:0]   rem_next;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, shreg[bris_pkg::AMT_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = bris_pkg::BITS_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[bris_pkg::BITS_W-1:0];
    end
  end

  assign done = busy && (step == bris_pkg::STEP_W'(bris_pkg::AMT_W - 1));

  // control: busy flag and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // partial remainder and dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[bris_pkg::AMT_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

### rtl/bris_datapath.sv
// packet store, config registers, rotation setup and output word register
`timescale 1ns / 1ps
`default_nettype none
module bris_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bris_pkg::ctrl_cmd_t  cmd,
  output bris_pkg::dp_stat_t        stat,
  input  wire logic                 cfg_wr,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic [7:0]           in_byte,
  output logic      [7:0]           out_byte,
  output logic                      out_last,
  output logic                      out_ovf,
  output logic                      out_valid,
  input  wire logic                 out_ready
);

  logic [1:0]                    direction;
  logic [bris_pkg::AMT_W-1:0]    rotate_amount;
  logic                          decode_mode;

  logic [7:0]                    store [bris_pkg::MAX_BYTES];
  logic [7:0]                    rd_data;
  logic [7:0]                    prev;
  logic [bris_pkg::CNT_W-1:0]    count;
  logic                          ovf_seen;

  logic [bris_pkg::ADDR_W-1:0]   ptr;
  logic [bris_pkg::ADDR_W-1:0]   ptr_next;
  logic [bris_pkg::ADDR_W-1:0]   b_idx;
  logic [2:0]                    bit_sh;
  logic                          invert;

  logic [bris_pkg::BITS_W-1:0]   nbits;
  logic [bris_pkg::BITS_W-1:0]   k;
  logic [bris_pkg::BITS_W-1:0]   s;
  logic                          pass;
  logic                          left;
  logic                          div_done;
  logic [15:0]                   window;
  logic [7:0]                    rot_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= bris_pkg::DIR_RIGHT;
      rotate_amount <= '0;
      decode_mode   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        bris_pkg::REG_DIRECTION: direction     <= cfg_data[1:0];
        bris_pkg::REG_AMOUNT:    rotate_amount <= cfg_data;
        bris_pkg::REG_DECODE:    decode_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // byte count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.store) begin
      if (count < bris_pkg::CNT_W'(bris_pkg::MAX_BYTES)) begin
        count <= count + 1'b1;
      end else begin
        ovf_seen <= 1'b1;
      end
    end else if (cmd.emit && stat.last_b) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end
  end

  // packet store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && (count < bris_pkg::CNT_W'(bris_pkg::MAX_BYTES))) begin
      store[count[bris_pkg::ADDR_W-1:0]] <= in_byte;
    end
    if (cmd.fetch) begin
      rd_data <= store[ptr];
    end
  end

  // modulo of the amount by the packet length in bits
  assign nbits = {count, 3'b000};

  bris_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (rotate_amount),
    .divisor  (nbits),
    .rem      (k),
    .done     (div_done)
  );

  // left-rotation equivalent of the requested rotation
  always_comb begin
    pass = (rotate_amount == '0) ||
           ((direction != bris_pkg::DIR_RIGHT) && (direction != bris_pkg::DIR_LEFT));
    left = (direction == bris_pkg::DIR_LEFT) ^ decode_mode;
    if (pass) begin
      s = '0;
    end else if (left || (k == '0)) begin
      s = k;
    end else begin
      s = nbits - k;
    end
  end

  // read pointer wraps at the packet length
  assign ptr_next = (bris_pkg::CNT_W'(ptr) == count - 1'b1) ? '0 : ptr + 1'b1;

  // rotation setup, read pointer and output byte index
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ptr    <= bris_pkg::ADDR_W'(s[bris_pkg::BITS_W-1:3]);
      bit_sh <= s[2:0];
      invert <= !pass;
      b_idx  <= '0;
    end else begin
      if (cmd.fetch) begin
        ptr <= ptr_next;
      end
      if (cmd.emit) begin
        b_idx <= b_idx + 1'b1;
      end
    end
    if (cmd.keep_prev) begin
      prev <= rd_data;
    end
  end

  // output byte spans two neighboring stored bytes
  always_comb begin
    window   = {prev, rd_data} << bit_sh;
    rot_byte = invert ? (window[15:8] ^ bris_pkg::INV_MASK) : window[15:8];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= rot_byte;
      out_last <= stat.last_b;
      out_ovf  <= ovf_seen;
    end
  end

  // status back to the controller
  always_comb begin
    stat.div_done = div_done;
    stat.out_busy = out_valid && !out_ready;
    stat.last_b   = (bris_pkg::CNT_W'(b_idx) == count - 1'b1);
  end

endmodule
`default_nettype wire

### rtl/bris_ctrl.sv
// controller state machine: load, modulo, setup and emit sequencing
`timescale 1ns / 1ps
`default_nettype none
module bris_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire bris_pkg::dp_stat_t  stat,
  output bris_pkg::ctrl_cmd_t      cmd
);

  bris_pkg::state_t state;
  bris_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bris_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      bris_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.start_div = 1'b1;
            state_next    = bris_pkg::ST_DIV;
          end
        end
      end
      bris_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = bris_pkg::ST_PREP;
        end
      end
      bris_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = bris_pkg::ST_PRIME;
      end
      bris_pkg::ST_PRIME: begin
        cmd.fetch  = 1'b1;
        state_next = bris_pkg::ST_RD;
      end
      bris_pkg::ST_RD: begin
        cmd.fetch     = 1'b1;
        cmd.keep_prev = 1'b1;
        state_next    = bris_pkg::ST_CALC;
      end
      bris_pkg::ST_CALC: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = stat.last_b ? bris_pkg::ST_LOAD : bris_pkg::ST_RD;
        end
      end
      default: begin
        state_next = bris_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/bris_checker.sv
// port-level checker for the scrambler and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
module bris_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word withdrawn while stalled");

  // a stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // the end of a packet stops input while the rotation is worked out
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after end of packet");

  // a new output word only appears while input is held off
  a_emit_no_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("output word emitted during packet load");

endmodule

bind buffer_rotate_invert_scrambler bris_checker u_bris_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

### sim/buffer_rotate_invert_scrambler_test.sv
// self-checking testbench for the packet rotate-invert scrambler
`timescale 1ns / 1ps
module buffer_rotate_invert_scrambler_test;
  import bris_pkg::*;

  // direction codes that make the block pass bytes through
  localparam logic [1:0] DIR_PASS     = 2'd2;
  localparam logic [1:0] DIR_PASS_ALT = 2'd3;
  // unused register index, writes to it are ignored
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  localparam int ITEM_TARGET = 270;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;
  // rotation that is a whole turn for every packet of 1 to 10 bytes
  localparam logic [15:0] WHOLE_TURN_AMT = 16'd20160;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;
  } scrambled_word_t;

  // predicts the scrambled words of each packet and checks them in order
  class scramble_scoreboard;
    logic [7:0]      pkt_bytes [MAX_BYTES];
    int unsigned     fill;
    bit              dropped;
    logic [1:0]      dir;
    logic [15:0]     amount;
    bit              decode;
    scrambled_word_t pending_words [$];
    int              errors;

    function new();
      fill    = 0;
      dropped = 0;
      dir     = DIR_RIGHT;
      amount  = '0;
      decode  = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_DIRECTION: dir = val[1:0];
        REG_AMOUNT:    amount = val;
        REG_DECODE:    decode = val[0];
        default: ;
      endcase
    endfunction

    // one input word accepted; on the last word the whole packet is predicted
    function void note_byte(logic [7:0] data, logic last);
      int unsigned     nbits;
      int unsigned     k;
      int unsigned     src;
      int unsigned     dst;
      int              b;
      int              i;
      bit              keep;
      bit              to_left;
      logic [7:0]      v;
      scrambled_word_t w;
      if (fill < MAX_BYTES) begin
        pkt_bytes[fill] = data;
        fill++;
      end else begin
        dropped = 1;
      end
      if (!last)
        return;
      nbits   = fill * 8;
      keep    = (amount == 0) || (dir != DIR_RIGHT && dir != DIR_LEFT);
      to_left = (dir == DIR_LEFT) ^ decode;
      k       = amount % nbits;
      for (b = 0; b < fill; b++) begin
        if (keep) begin
          v = pkt_bytes[b];
        end else begin
          // bit 0 of the string is the msb of the first byte
          for (i = 0; i < 8; i++) begin
            dst = b * 8 + i;
            src = to_left ? (dst + k) % nbits : (dst + nbits - k) % nbits;
            v[7 - i] = pkt_bytes[src >> 3][7 - (src & 7)];
          end
          v = ~v;
        end
        w.out_byte = v;
        w.out_last = (b + 1 == fill);
        w.overflow = dropped;
        pending_words.push_back(w);
      end
      fill    = 0;
      dropped = 0;
    endfunction

    function void check_word(logic [7:0] data, logic last, logic ovf);
      scrambled_word_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h last %b overflow %b", data, last, ovf);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      if (data !== w.out_byte) begin
        $error("out_byte: expected %h, got %h", w.out_byte, data);
        errors++;
      end
      if (last !== w.out_last) begin
        $error("out_last: expected %b, got %b", w.out_last, last);
        errors++;
      end
      if (ovf !== w.overflow) begin
        $error("overflow: expected %b, got %b", w.overflow, ovf);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] out_byte
  logic        m_tlast;
  logic        m_tuser;        // [0] overflow
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  scramble_scoreboard sb;
  int  words_sent = 0;
  int  burst_left = 0;
  int  quiet_cycles = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  pace_mode = 0;
  int  pace_left = 0;
  int  pace_count = 0;
  logic ready_next;

  always #6 clk = ~clk;

  buffer_rotate_invert_scrambler u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // receiver pacing: one long hold-off on request, otherwise changing patterns
  always @(posedge clk) begin
    pace_count++;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_mode = $urandom_range(0, 3);
        pace_left = $urandom_range(5, 60);
      end
      pace_left--;
      case (pace_mode)
        0: ready_next = 1'b1;
        1: ready_next = 1'($urandom_range(0, 1));
        2: ready_next = ($urandom_range(0, 3) == 0);
        default: ready_next = (pace_count % 5) != 0;
      endcase
    end
    m_tready <= ready_next;
  end

  // accepted words go to the scoreboard; watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        sb.check_word(m_tdata, m_tlast, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one register write, then the channel goes idle
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // direction and decode go out with random upper bits that must be ignored
  task automatic set_regs(input logic [1:0] d, input logic [15:0] amt, input bit dec);
    cfg_write(REG_DIRECTION, {14'($urandom_range(0, 16383)), d});
    cfg_write(REG_AMOUNT, amt);
    cfg_write(REG_DECODE, {15'($urandom_range(0, 32767)), dec});
  endtask

  // offer one word; between bursts the sender goes quiet for a while
  task automatic send_word(input logic [7:0] data, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic send_packet(input int len);
    int j;
    for (j = 0; j < len; j++)
      send_word(8'($urandom_range(0, 255)), j == len - 1);
  endtask

  // lets the block run dry before registers change
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    // the monitor has noted the last accepted word after this edge
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(MAX_BYTES + 1, MAX_BYTES + 3);
    if (r < 8) return MAX_BYTES;
    if (r < 16) return $urandom_range(11, MAX_BYTES - 1);
    return $urandom_range(1, 10);
  endfunction

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return WHOLE_TURN_AMT;
      4, 5: return 16'($urandom_range(1, 40));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [1:0] pick_dir();
    case ($urandom_range(0, 5))
      0: return DIR_PASS;
      1: return DIR_PASS_ALT;
      2, 3: return DIR_LEFT;
      default: return DIR_RIGHT;
    endcase
  endfunction

  initial begin
    int npk;
    int p;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: pass through
    send_word(8'h3C, 1'b0);
    send_word(8'hFF, 1'b1);
    wait_idle();

    // rotate right by one, then a one-byte packet
    set_regs(DIR_RIGHT, 16'd1, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b1);
    send_word(8'hFF, 1'b1);
    wait_idle();

    // rotate left by three
    cfg_write(REG_DIRECTION, {14'd0, DIR_LEFT});
    cfg_write(REG_AMOUNT, 16'd3);
    send_word(8'h00, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b1);
    wait_idle();

    // whole turn for a two-byte packet: bits stay, bytes still inverted
    cfg_write(REG_AMOUNT, 16'd16);
    send_word(8'h81, 1'b0);
    send_word(8'h7E, 1'b1);
    wait_idle();

    // decode reverses direction, largest amount
    set_regs(DIR_RIGHT, 16'hFFFF, 1'b1);
    send_word(8'hF0, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'h12, 1'b1);
    wait_idle();

    // invalid direction passes through; write to unused index is ignored
    cfg_write(REG_DIRECTION, 16'hFFFE);
    cfg_write(REG_AMOUNT, 16'd5);
    cfg_write(REG_UNUSED, 16'hFFFF);
    send_word(8'hC3, 1'b1);
    wait_idle();

    // other invalid direction with decode set through all-ones data
    cfg_write(REG_DIRECTION, 16'hFFFF);
    cfg_write(REG_DECODE, 16'hFFFF);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b1);
    wait_idle();

    // zero amount passes through even with a valid direction
    set_regs(DIR_LEFT, 16'd0, 1'b0);
    send_word(8'h99, 1'b1);
    wait_idle();

    // store full: last word dropped, then the last two words dropped
    set_regs(DIR_RIGHT, 16'd7, 1'b0);
    send_packet(MAX_BYTES + 1);
    send_packet(MAX_BYTES + 2);
    wait_idle();

    // random phases; the receiver holds off once while packets keep coming
    hold_req <= 1'b1;
    while (words_sent < ITEM_TARGET) begin
      set_regs(pick_dir(), pick_amount(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0)
        cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
      npk = $urandom_range(1, 4);
      for (p = 0; p < npk; p++)
        send_packet(pick_len());
      wait_idle();
    end

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
